// File: src/vgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_pkg
// Shared types, constants and helpers of the volume gradient magnitude block.
// ----------------------------------------------------------------------------
package vgm_pkg;

    // default volume limits
    localparam int DEF_MAX_X = 256;
    localparam int DEF_MAX_Y = 256;
    localparam int DEF_MAX_Z = 4096;

    // fixed field widths
    localparam int VOX_W  = 16;
    localparam int WGT_W  = 12;
    localparam int PROD_W = VOX_W + WGT_W;     // weighted difference
    localparam int SUM_W  = 2 * PROD_W + 2;    // sum of three squares
    localparam int ROOT_W = SUM_W / 2;
    localparam int FRAC_W = 8;                 // Q4.8 weight fraction
    localparam int MAG_W  = 16;

    // configuration register indexes
    localparam logic [2:0] REG_SIZE_X   = 3'd0;
    localparam logic [2:0] REG_SIZE_Y   = 3'd1;
    localparam logic [2:0] REG_SIZE_Z   = 3'd2;
    localparam logic [2:0] REG_WEIGHT_X = 3'd3;
    localparam logic [2:0] REG_WEIGHT_Y = 3'd4;
    localparam logic [2:0] REG_WEIGHT_Z = 3'd5;

    // axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // input op codes
    localparam logic OP_VOXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic             op;
        logic [VOX_W-1:0] voxel;
    } t_in_word;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last;
    } t_out_word;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_WAIT   = 12'b000000000010,
        ST_DECIDE = 12'b000000000100,
        ST_RDM    = 12'b000000001000,
        ST_RDP    = 12'b000000010000,
        ST_DIF    = 12'b000000100000,
        ST_MULW   = 12'b000001000000,
        ST_SQ     = 12'b000010000000,
        ST_RGO    = 12'b000100000000,
        ST_RWAIT  = 12'b001000000000,
        ST_EMIT   = 12'b010000000000,
        ST_WRITE  = 12'b100000000000
    } t_state;

    // size of 0 acts as 1, above the limit acts as the limit
    function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v < 32'd1) r = 32'd1;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

// File: src/vgm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vgm_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgm_isqrt
// Serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vgm_isqrt
    import vgm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int STEPS = SUM_W / 2;
    localparam int CW    = $clog2(STEPS);

    logic [SUM_W-1:0] r_rem, r_res, r_bit;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [SUM_W-1:0] trial;
    logic             fits;

    // one compare and subtract per step
    assign trial = r_res + r_bit;
    assign fits  = (r_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_value;
                r_res  <= '0;
                r_bit  <= SUM_W'(1) << (SUM_W - 2);
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (fits) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// File: src/volume_gradient_magnitude_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_gradient_magnitude_top
// 3D central-difference gradient magnitude over a streamed voxel volume.
// ----------------------------------------------------------------------------
// Voxels come in raster order; results trail the input by about one plane and
// drain words flush the tail. One word is handled at a time; a word that
// releases a result goes through six reads through the plane ring's one read
// port, a weight multiply and a square per axis and the 29-step serial square
// root. The input is stalled while a word is in work. The plane ring holds
// 2*MAX_X*MAX_Y voxels in RAM.
// ----------------------------------------------------------------------------
module volume_gradient_magnitude_top
    import vgm_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW    = $clog2(MAX_X + 1);
    localparam int YW    = $clog2(MAX_Y + 1);
    localparam int ZW    = $clog2(MAX_Z + 1);
    localparam int DEPTH = 2 * MAX_X * MAX_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int DZW   = $clog2(MAX_X * MAX_Y + 1);
    localparam longint unsigned VOL = longint'(MAX_X) * longint'(MAX_Y) * longint'(MAX_Z);
    localparam int LW    = $clog2(VOL + 1);

    // configuration registers
    logic [8:0]       r_size_x, r_size_y;
    logic [12:0]      r_size_z;
    logic [WGT_W-1:0] r_wgt_x, r_wgt_y, r_wgt_z;

    // derived sizes
    logic [XW-1:0]  sx;
    logic [YW-1:0]  sy;
    logic [ZW-1:0]  sz;
    logic [DZW-1:0] r_dz;
    logic [LW-1:0]  r_total;

    // stream state
    t_state           r_state;
    logic [LW-1:0]    r_recv, r_count;
    logic [AW-1:0]    r_wp, r_rp;
    logic [XW-1:0]    r_ox;
    logic [YW-1:0]    r_oy;
    logic [ZW-1:0]    r_oz;
    t_in_word         r_word;
    logic             r_have, r_emit;
    logic [1:0]       r_ax;
    logic [VOX_W-1:0] r_a, r_diff;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0] r_acc;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             cfg_wr;
    logic             have_c, emit_c;
    logic [LW:0]      r_plus;
    logic [DZW-1:0]   ax_d;
    logic             ax_lo, ax_hi;
    logic [WGT_W-1:0] ax_w;
    logic [AW-1:0]    raddr;
    logic [VOX_W-1:0] rdata, pval;
    logic             bypass, lo_bypass;
    logic             sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [ROOT_W-FRAC_W-1:0] mag_full;
    logic             is_last;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [DZW-1:0] d);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(d);
        if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [DZW-1:0] d);
        logic [AW:0] s;
        if ({1'b0, a} >= (AW+1)'(d)) s = {1'b0, a} - (AW+1)'(d);
        else s = {1'b0, a} + (AW+1)'(DEPTH) - (AW+1)'(d);
        return s[AW-1:0];
    endfunction

    // size clamping and volume products, one multiply per register
    assign sx = XW'(clamp_size(32'(r_size_x), 32'(MAX_X)));
    assign sy = YW'(clamp_size(32'(r_size_y), 32'(MAX_Y)));
    assign sz = ZW'(clamp_size(32'(r_size_z), 32'(MAX_Z)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz    <= DZW'(1);
            r_total <= LW'(1);
        end else begin
            r_dz    <= DZW'(sx * sy);
            r_total <= LW'(r_dz * sz);
        end
    end

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[4:2])
            REG_SIZE_X:   prdata = 32'(r_size_x);
            REG_SIZE_Y:   prdata = 32'(r_size_y);
            REG_SIZE_Z:   prdata = 32'(r_size_z);
            REG_WEIGHT_X: prdata = 32'(r_wgt_x);
            REG_WEIGHT_Y: prdata = 32'(r_wgt_y);
            REG_WEIGHT_Z: prdata = 32'(r_wgt_z);
            default:      prdata = '0;
        endcase
    end

    // result release decision
    assign have_c = (r_word.op == OP_VOXEL) && (r_recv < r_total);
    assign r_plus = {1'b0, r_recv} + (LW+1)'(have_c);
    assign emit_c = (r_count < r_total) &&
                    ((r_plus >= {1'b0, r_total}) ||
                     (r_plus > ({1'b0, r_count} + (LW+1)'(r_dz))));

    // per-axis neighbor offset, border checks and weight
    always_comb begin
        case (r_ax)
            AX_X: begin
                ax_d  = DZW'(1);
                ax_lo = (r_ox != '0);
                ax_hi = ({1'b0, r_ox} + 1'b1) < {1'b0, sx};
                ax_w  = r_wgt_x;
            end
            AX_Y: begin
                ax_d  = DZW'(sx);
                ax_lo = (r_oy != '0);
                ax_hi = ({1'b0, r_oy} + 1'b1) < {1'b0, sy};
                ax_w  = r_wgt_y;
            end
            default: begin
                ax_d  = r_dz;
                ax_lo = (r_oz != '0);
                ax_hi = ({1'b0, r_oz} + 1'b1) < {1'b0, sz};
                ax_w  = r_wgt_z;
            end
        endcase
    end

    // ring read address, next neighbor takes the arriving voxel
    always_comb begin
        if (r_state == ST_RDM) begin
            raddr = ax_lo ? ring_sub(r_rp, ax_d) : r_rp;
        end else begin
            raddr = ax_hi ? ring_add(r_rp, ax_d) : r_rp;
        end
    end

    // a neighbor that is the voxel arriving right now is taken from the word
    assign bypass    = r_have &&
                       (ax_hi ? (({1'b0, r_count} + (LW+1)'(ax_d)) == {1'b0, r_recv})
                              : (r_count == r_recv));
    assign lo_bypass = r_have && !ax_lo && (r_count == r_recv);
    assign pval      = bypass ? r_word.voxel : rdata;

    vgm_ram #(
        .WIDTH (VOX_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_WRITE) && r_have),
        .i_waddr (r_wp),
        .i_wdata (r_word.voxel),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign sq_start = (r_state == ST_RGO);

    vgm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign mag_full = sq_root[ROOT_W-1:FRAC_W];
    assign is_last  = ({1'b0, r_count} + 1'b1) == {1'b0, r_total};

    // sequencer, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_size_x    <= 9'd1;
            r_size_y    <= 9'd1;
            r_size_z    <= 13'd1;
            r_wgt_x     <= WGT_W'(256);
            r_wgt_y     <= WGT_W'(256);
            r_wgt_z     <= WGT_W'(256);
            r_recv      <= '0;
            r_count     <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_oz        <= '0;
            r_have      <= 1'b0;
            r_emit      <= 1'b0;
            r_ax        <= AX_X;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_SIZE_X:   r_size_x <= pwdata[8:0];
                    REG_SIZE_Y:   r_size_y <= pwdata[8:0];
                    REG_SIZE_Z:   r_size_z <= pwdata[12:0];
                    REG_WEIGHT_X: r_wgt_x  <= pwdata[WGT_W-1:0];
                    REG_WEIGHT_Y: r_wgt_y  <= pwdata[WGT_W-1:0];
                    REG_WEIGHT_Z: r_wgt_z  <= pwdata[WGT_W-1:0];
                    default: ;
                endcase
                if (paddr[4:2] == REG_SIZE_X || paddr[4:2] == REG_SIZE_Y ||
                    paddr[4:2] == REG_SIZE_Z) begin
                    r_recv  <= '0;
                    r_count <= '0;
                    r_wp    <= '0;
                    r_rp    <= '0;
                    r_ox    <= '0;
                    r_oy    <= '0;
                    r_oz    <= '0;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_word  <= i_in_word;
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    r_have  <= have_c;
                    r_emit  <= emit_c;
                    r_acc   <= '0;
                    r_ax    <= AX_X;
                    r_state <= emit_c ? ST_RDM : ST_WRITE;
                end
                ST_RDM: begin
                    r_state <= ST_RDP;
                end
                ST_RDP: begin
                    r_a     <= lo_bypass ? r_word.voxel : rdata;
                    r_state <= ST_DIF;
                end
                ST_DIF: begin
                    r_diff  <= (r_a >= pval) ? (r_a - pval) : (pval - r_a);
                    r_state <= ST_MULW;
                end
                ST_MULW: begin
                    r_prod  <= r_diff * ax_w;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_acc <= r_acc + SUM_W'(r_prod * r_prod);
                    if (r_ax == AX_Z) begin
                        r_state <= ST_RGO;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= ST_RDM;
                    end
                end
                ST_RGO: begin
                    r_state <= ST_RWAIT;
                end
                ST_RWAIT: begin
                    if (sq_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_word.magnitude <= (mag_full > (ROOT_W-FRAC_W)'(16'hFFFF)) ?
                                                16'hFFFF : mag_full[MAG_W-1:0];
                        r_out_word.last      <= is_last;
                        r_out_valid          <= 1'b1;
                        r_state              <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (r_have) begin
                        r_recv <= r_recv + 1'b1;
                        r_wp   <= ring_add(r_wp, DZW'(1));
                    end
                    if (r_emit) begin
                        r_count <= r_count + 1'b1;
                        r_rp    <= ring_add(r_rp, DZW'(1));
                        if (({1'b0, r_ox} + 1'b1) == {1'b0, sx}) begin
                            r_ox <= '0;
                            if (({1'b0, r_oy} + 1'b1) == {1'b0, sy}) begin
                                r_oy <= '0;
                                r_oz <= r_oz + 1'b1;
                            end else begin
                                r_oy <= r_oy + 1'b1;
                            end
                        end else begin
                            r_ox <= r_ox + 1'b1;
                        end
                        // volume complete, restart stream
                        if (is_last) begin
                            r_recv  <= '0;
                            r_count <= '0;
                            r_wp    <= '0;
                            r_rp    <= '0;
                            r_ox    <= '0;
                            r_oy    <= '0;
                            r_oz    <= '0;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // results never run ahead of received voxels
    a_count_le_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_recv) else $error("result count ahead of input");

    // input never overruns the volume
    a_recv_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_recv <= r_total)) else $error("input past volume end");

    // square root finishes only while awaited
    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_RWAIT)) else $error("unexpected square root done");

endmodule
